/* hdl/pip_pkg.sv */
package pip_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 12;

	// query sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT
	} pip_state_t;

	// tag that travels with each corner read
	typedef struct packed {
		logic vld;        // read issued this cycle
		logic load_prev;  // closing vertex: seeds the previous corner
		logic eval;       // read returns the far end of an edge
		logic last;       // final read of the query
	} pip_req_t;

endpackage

/* hdl/pip_mem.sv */
module pip_mem #(
	parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
	parameter int WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/pip_edge.sv */
module pip_edge #(
	parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pip_pkg::pip_req_t          req,
	input  logic [2*COORD_WIDTH-1:0]   rd_data,
	input  logic [COORD_WIDTH-1:0]     qx,
	input  logic [COORD_WIDTH-1:0]     qy,
	output logic                       res_vld,
	output logic                       res_inside
);

	import pip_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	pip_req_t req_s1;

	logic [COORD_WIDTH-1:0] ex, ey;
	logic [COORD_WIDTH-1:0] sx_q, sy_q;
	logic                   s_above, e_above;
	logic signed [DW-1:0]   d_eq, d_es, d_ys, d_xq;
	logic signed [PW-1:0]   lhs, rhs;

	logic signed [PW-1:0]   lhs_s2, rhs_s2;
	logic                   cross_s2, e_above_s2, last_s2, vld_s2;

	logic                   toggle;
	logic                   inside_q;
	logic                   res_vld_q, res_inside_q;

	// align tag with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1 <= req;
		end
	end

	assign ex = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
	assign ey = rd_data[COORD_WIDTH-1:0];

	assign s_above = (sy_q >= qy);
	assign e_above = (ey >= qy);

	assign d_eq = $signed({1'b0, ey}) - $signed({1'b0, qy});
	assign d_es = $signed({1'b0, ex}) - $signed({1'b0, sx_q});
	assign d_ys = $signed({1'b0, ey}) - $signed({1'b0, sy_q});
	assign d_xq = $signed({1'b0, ex}) - $signed({1'b0, qx});
	assign lhs  = d_eq * d_es;
	assign rhs  = d_ys * d_xq;

	// previous corner of the walk
	always_ff @(posedge clk) begin
		if (req_s1.vld && (req_s1.load_prev || req_s1.eval)) begin
			sx_q <= ex;
			sy_q <= ey;
		end
	end

	always_ff @(posedge clk) begin
		lhs_s2     <= lhs;
		rhs_s2     <= rhs;
		e_above_s2 <= e_above;
		cross_s2   <= req_s1.eval && (s_above != e_above);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= req_s1.vld;
			last_s2 <= req_s1.vld && req_s1.last;
		end
	end

	// edge toggles when the point sits on the side the edge direction favors
	assign toggle = vld_s2 && cross_s2 && ((lhs_s2 <= rhs_s2) == e_above_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			res_vld_q    <= 1'b0;
			res_inside_q <= 1'b0;
		end else begin
			res_vld_q <= last_s2;
			if (last_s2) begin
				res_inside_q <= inside_q ^ toggle;
				inside_q     <= 1'b0;
			end else if (toggle) begin
				inside_q <= ~inside_q;
			end
		end
	end

	assign res_vld    = res_vld_q;
	assign res_inside = res_inside_q;

endmodule

/* hdl/point_in_polygon_test.sv */
// Point-in-polygon tester, even-odd crossing rule. Vertices are loaded one per
// transfer (kind = 0); first_vertex = 1 drops the old polygon and its overflow
// flag first. A vertex beyond MAX_VERTICES is dropped and sets overflowed. A
// query (kind = 1) answers with one result: done is high for exactly one cycle
// with inside_res, vertex_total and overflowed. There is no back-pressure; the
// receiver must take the result in that cycle. A load leaves busy low. A
// query keeps busy high up to and including done, so the next transfer can
// follow only once the result is out: the corners sit in one memory with a
// single read port and the walk reads n + 1 entries, n the number of held
// vertices, one per cycle, plus the read latency and the two-stage
// cross-product pipe. An empty polygon answers outside.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic [COORD_WIDTH-1:0]               point_x,
	input  logic [COORD_WIDTH-1:0]               point_y,
	input  logic                                 first_vertex,
	output logic                                 done,
	output logic                                 inside_res,
	output logic [$clog2(MAX_VERTICES+1)-1:0]    vertex_total,
	output logic                                 overflowed
);

	import pip_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AW    = $clog2(MAX_VERTICES);

	pip_state_t state_q, state_d;
	pip_req_t   req;

	logic             accept, load_acc, query_acc;
	logic [CNT_W-1:0] count_q, eff_cnt, cnt_m1;
	logic             lost_q, room;

	logic [AW-1:0]    idx_q, last_addr_q, rd_addr;
	logic             head_q;
	logic [COORD_WIDTH-1:0] qx_q, qy_q;

	logic [2*COORD_WIDTH-1:0] rd_data;
	logic             res_vld;

	// transfer decode
	assign accept    = start && !busy;
	assign load_acc  = accept && !kind;
	assign query_acc = accept && kind;

	// a first vertex restarts the list at entry zero
	assign eff_cnt = first_vertex ? '0 : count_q;
	assign room    = (eff_cnt < CNT_W'(MAX_VERTICES));
	assign cnt_m1  = count_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lost_q  <= 1'b0;
		end else if (load_acc) begin
			count_q <= room ? eff_cnt + CNT_W'(1) : eff_cnt;
			lost_q  <= first_vertex ? 1'b0 : (lost_q || !room);
		end
	end

	// corner store: x in the upper half, y in the lower
	pip_mem #(
		.DEPTH (MAX_VERTICES),
		.WIDTH (2 * COORD_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (load_acc && room),
		.wr_addr (eff_cnt[AW-1:0]),
		.wr_data ({point_x, point_y}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Walk order: closing vertex n-1 first, then entries 0 .. n-1.
	// Loads are held off by busy during the walk, so reads never meet a write.
	assign rd_addr = idx_q;

	always_comb begin
		state_d = state_q;
		req     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					if (count_q == '0) begin
						// empty polygon: a lone tag with no edge
						req.vld  = 1'b1;
						req.last = 1'b1;
						state_d  = ST_WAIT;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				req.vld       = 1'b1;
				req.load_prev = head_q;
				req.eval      = !head_q;
				req.last      = !head_q && (idx_q == last_addr_q);
				if (req.last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (res_vld) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_addr_q <= '0;
			head_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (query_acc) begin
				idx_q       <= cnt_m1[AW-1:0];
				last_addr_q <= cnt_m1[AW-1:0];
				head_q      <= 1'b1;
			end else if (state_q == ST_WALK) begin
				head_q <= 1'b0;
				idx_q  <= head_q ? '0 : idx_q + AW'(1);
			end
		end
	end

	// query point, held for the whole walk
	always_ff @(posedge clk) begin
		if (query_acc) begin
			qx_q <= point_x;
			qy_q <= point_y;
		end
	end

	pip_edge #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rd_data    (rd_data),
		.qx         (qx_q),
		.qy         (qy_q),
		.res_vld    (res_vld),
		.res_inside (inside_res)
	);

	// count and flag cannot change while a query is in flight
	assign busy         = (state_q != ST_IDLE);
	assign done         = res_vld;
	assign vertex_total = count_q;
	assign overflowed   = lost_q;

endmodule

/* hdl/pip_chk.sv */
module pip_chk #(
	parameter int CNT_W = 7
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             kind,
	input logic             first_vertex,
	input logic             done,
	input logic [CNT_W-1:0] vertex_total,
	input logic             overflowed
);

	// result only shows up while the query holds the block
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without a query in flight");

	// a load is a transfer that raises neither busy nor a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> (!busy && !done))
		else $error("load produced busy or a result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> busy)
		else $error("query did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("busy held past the result");

	// a first vertex leaves exactly one vertex and clears the drop flag
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind && first_vertex) |=>
			((vertex_total == CNT_W'(1)) && !overflowed))
		else $error("polygon restart did not reset the count");

endmodule

bind point_in_polygon_test pip_chk #(
	.CNT_W (CNT_W)
) u_pip_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.first_vertex (first_vertex),
	.done         (done),
	.vertex_total (vertex_total),
	.overflowed   (overflowed)
);
